// File: sv/mrutc_pkg.sv
// Package: widths, types and constants for the MRU buffer tag cache.
package mrutc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int DEV_W   = 8;
  localparam int BLK_W   = 48;
  localparam int SIZE_W  = 13;
  localparam int HND_W   = 16;

  typedef logic [DEV_W-1:0]  dev_t;
  typedef logic [BLK_W-1:0]  blk_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [HND_W-1:0]  hnd_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef enum logic {
    ACT_LOOKUP  = 1'b0,
    ACT_INSTALL = 1'b1
  } action_t;

  typedef struct packed {
    dev_t  dev;
    blk_t  blk;
    size_t size;
    hnd_t  hnd;
  } slot_t;

  typedef struct packed {
    action_t action;
    dev_t    dev;
    blk_t    blk;
    size_t   size;
    hnd_t    hnd;
  } item_t;

  typedef struct packed {
    logic tag_hit;
    idx_t tag_idx;
    hnd_t tag_hnd;
    logic dup_hit;
    idx_t dup_idx;
  } match_t;

endpackage

// File: sv/mrutc_in_if.sv
// Interface: request channel (lookup or install) of the MRU buffer tag cache.
interface mrutc_in_if;
  import mrutc_pkg::*;

  logic  valid;
  logic  ready;
  logic  action;
  dev_t  device_id;
  blk_t  block_number;
  size_t block_size;
  hnd_t  handle;

  modport source (
    output valid, action, device_id, block_number, block_size, handle,
    input  ready
  );

  modport sink (
    input  valid, action, device_id, block_number, block_size, handle,
    output ready
  );
endinterface

// File: sv/mrutc_out_if.sv
// Interface: result channel of the MRU buffer tag cache.
interface mrutc_out_if;
  import mrutc_pkg::*;

  logic valid;
  logic ready;
  logic hit;
  hnd_t found_handle;
  logic evicted_valid;
  hnd_t evicted_handle;

  modport source (
    output valid, hit, found_handle, evicted_valid, evicted_handle,
    input  ready
  );

  modport sink (
    input  valid, hit, found_handle, evicted_valid, evicted_handle,
    output ready
  );
endinterface

// File: sv/mrutc_match.sv
// Module: parallel tag and handle comparators with first-match priority select.
module mrutc_match (
  input  logic [mrutc_pkg::ENTRIES-1:0] slot_valid,
  input  mrutc_pkg::slot_t              slots [mrutc_pkg::ENTRIES],
  input  mrutc_pkg::dev_t               dev,
  input  mrutc_pkg::blk_t               blk,
  input  mrutc_pkg::size_t              size,
  input  mrutc_pkg::hnd_t               hnd,
  output mrutc_pkg::match_t             match
);
  import mrutc_pkg::*;

  logic [ENTRIES-1:0] tag_vec;
  logic [ENTRIES-1:0] dup_vec;

  // Compare every slot at once.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      tag_vec[i] = slot_valid[i] && slots[i].dev == dev &&
                   slots[i].blk == blk && slots[i].size == size;
      dup_vec[i] = slot_valid[i] && slots[i].hnd == hnd;
    end
  end

  // Keep the lowest-index match of each kind.
  always_comb begin
    match = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tag_vec[i] && !match.tag_hit) begin
        match.tag_hit = 1'b1;
        match.tag_idx = IDX_W'(i);
        match.tag_hnd = slots[i].hnd;
      end
      if (dup_vec[i] && !match.dup_hit) begin
        match.dup_hit = 1'b1;
        match.dup_idx = IDX_W'(i);
      end
    end
  end
endmodule

// File: sv/mru_buffer_tag_cache.sv
// Top level: 16-entry move-to-front buffer tag cache with registered request and result.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-----------------------------------------------------
//  in_chan | in  | valid / ready | action, device_id, block_number, block_size, handle
//  out_chan| out | valid / ready | hit, found_handle, evicted_valid, evicted_handle
//
// One transaction per cycle sustained while out_chan.ready stays high. An accepted
// request lands in the request register; from there the slot comparators and the shift
// network run and the slot array and result register update together.
// Reset (synchronous, rst_n low) clears the valid bits of the slots and both stages.
// A stalled result holds the request stage; in_chan.ready drops only when both
// stages are full and out_chan.ready is low.
module mru_buffer_tag_cache (
  input logic        clk,
  input logic        rst_n,
  mrutc_in_if.sink   in_chan,
  mrutc_out_if.source out_chan
);
  import mrutc_pkg::*;

  // Request stage
  logic  s1_valid_r;
  item_t s1_item_r;
  logic  s1_go;

  // Slot array: slot 0 is the most recently used entry
  logic [ENTRIES-1:0] slot_valid_r;
  logic [ENTRIES-1:0] slot_valid_nxt;
  slot_t              slot_r   [ENTRIES];
  slot_t              slot_nxt [ENTRIES];

  // Result register
  logic out_valid_r;
  logic hit_r, hit_nxt;
  hnd_t found_handle_r, found_handle_nxt;
  logic evicted_valid_r, evicted_valid_nxt;
  hnd_t evicted_handle_r, evicted_handle_nxt;

  match_t match;
  logic   do_shift;
  idx_t   stop_idx;
  slot_t  front_slot;

  // Advance the request when the result register is free or being drained.
  assign s1_go         = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_item_r.action <= action_t'(in_chan.action);
      s1_item_r.dev    <= in_chan.device_id;
      s1_item_r.blk    <= in_chan.block_number;
      s1_item_r.size   <= in_chan.block_size;
      s1_item_r.hnd    <= in_chan.handle;
    end
  end

  mrutc_match u_match (
    .slot_valid (slot_valid_r),
    .slots      (slot_r),
    .dev        (s1_item_r.dev),
    .blk        (s1_item_r.blk),
    .size       (s1_item_r.size),
    .hnd        (s1_item_r.hnd),
    .match      (match)
  );

  // Decide what moves to the front and where the shift stops.
  //  lookup hit : matched entry moves to the front, slots above it shift down
  //  lookup miss: nothing changes
  //  install    : new entry at the front; shift stops at an old copy of the
  //               same handle (dropped), else the last slot falls out
  always_comb begin
    front_slot.dev  = s1_item_r.dev;
    front_slot.blk  = s1_item_r.blk;
    front_slot.size = s1_item_r.size;
    front_slot.hnd  = s1_item_r.hnd;
    do_shift        = 1'b0;
    stop_idx        = IDX_W'(ENTRIES - 1);

    hit_nxt            = 1'b0;
    found_handle_nxt   = '0;
    evicted_valid_nxt  = 1'b0;
    evicted_handle_nxt = '0;

    case (s1_item_r.action)
      ACT_LOOKUP: begin
        if (match.tag_hit) begin
          do_shift         = 1'b1;
          stop_idx         = match.tag_idx;
          front_slot.hnd   = match.tag_hnd;
          hit_nxt          = 1'b1;
          found_handle_nxt = match.tag_hnd;
        end
      end
      ACT_INSTALL: begin
        do_shift = 1'b1;
        if (match.dup_hit) begin
          stop_idx = match.dup_idx;
        end else if (slot_valid_r[ENTRIES-1]) begin
          evicted_valid_nxt  = 1'b1;
          evicted_handle_nxt = slot_r[ENTRIES-1].hnd;
        end
      end
      default: begin
        do_shift = 1'b0;
      end
    endcase
  end

  // Shift network: every slot up to the stop point takes its upper neighbor.
  always_comb begin
    slot_valid_nxt = slot_valid_r;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    if (do_shift) begin
      slot_valid_nxt[0] = 1'b1;
      slot_nxt[0]       = front_slot;
      for (int i = 1; i < ENTRIES; i++) begin
        if (IDX_W'(i) <= stop_idx) begin
          slot_valid_nxt[i] = slot_valid_r[i-1];
          slot_nxt[i]       = slot_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (s1_go) begin
      slot_valid_r <= slot_valid_nxt;
    end
  end

  // Slot contents carry no reset; valid bits gate every read.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_r[i] <= slot_nxt[i];
      end
    end
  end

  // Result register: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      hit_r            <= hit_nxt;
      found_handle_r   <= found_handle_nxt;
      evicted_valid_r  <= evicted_valid_nxt;
      evicted_handle_r <= evicted_handle_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.hit            = hit_r;
  assign out_chan.found_handle   = found_handle_r;
  assign out_chan.evicted_valid  = evicted_valid_r;
  assign out_chan.evicted_handle = evicted_handle_r;
endmodule
